// ----- src/rfe_pkg.sv -----
// Shared types, constants and helper functions of the RF frame builder and encoder.
package rfe_pkg;

  localparam int unsigned MESSAGE_BYTES = 31;
  localparam int unsigned HEADER_PAIRS  = 6;
  localparam int unsigned MAX_PAYLOAD   = 5;
  localparam int unsigned CFG_IDX_W     = 4;

  localparam logic [7:0] HDR_MARK_A = 8'hF0;
  localparam logic [7:0] HDR_MARK_B = 8'hFE;
  localparam logic [7:0] HDR_MARK_C = 8'h5A;
  localparam logic [7:0] PAD_BYTE   = 8'hF0;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TX_ID   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CNT_LOW = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_CNT_HI  = CFG_IDX_W'(3);

  typedef enum logic [1:0] {
    KIND_HDR = 2'd0,
    KIND_MSG = 2'd1,
    KIND_SUM = 2'd2
  } cell_kind_e;

  typedef struct packed {
    cell_kind_e  kind;
    logic [7:0]  hi;
    logic [7:0]  lo;
  } rfe_cell_t;

  typedef struct packed {
    logic load;
    logic shift;
  } rfe_cell_ctl_t;

  typedef struct packed {
    logic [39:0] payload;
    logic [2:0]  payload_len;
    logic [31:0] id_salt;
    logic [23:0] header_random_a;
    logic [23:0] header_random_b;
    logic [15:0] header_random_c;
  } rfe_req_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       last;
  } rfe_result_t;

  function automatic logic [5:0] code4to6(input logic [3:0] nib);
    logic [5:0] c;
    unique case (nib)
      4'h0: c = 6'h2d;
      4'h1: c = 6'h2e;
      4'h2: c = 6'h33;
      4'h3: c = 6'h35;
      4'h4: c = 6'h36;
      4'h5: c = 6'h29;
      4'h6: c = 6'h2a;
      4'h7: c = 6'h3c;
      4'h8: c = 6'h23;
      4'h9: c = 6'h25;
      4'hA: c = 6'h26;
      4'hB: c = 6'h39;
      4'hC: c = 6'h3a;
      4'hD: c = 6'h32;
      4'hE: c = 6'h3e;
      default: c = 6'h3f;
    endcase
    return c;
  endfunction

  // Plain message byte at position j; the checksum position is filled later.
  function automatic logic [7:0] msg_byte(
    input int unsigned j,
    input int unsigned msg_bytes,
    input logic [63:0] cnt_lo,
    input logic [63:0] cnt_hi,
    input logic [31:0] tx_id,
    input logic [31:0] salt,
    input logic [2:0]  len,
    input logic [39:0] payload
  );
    logic [7:0]  b;
    int unsigned k;
    b = PAD_BYTE;
    k = 0;
    if (j < 8) begin
      b = cnt_lo[8*j +: 8];
    end else if (j < 16) begin
      b = cnt_hi[8*(j-8) +: 8];
    end else if (j < 24) begin
      k = (j - 16) >> 1;
      b = ((j & 1) == 0) ? tx_id[8*k +: 8] : salt[8*k +: 8];
    end else if (j == 24) begin
      b = {5'd0, len};
    end else if ((j - 25) < MAX_PAYLOAD) begin
      k = j - 25;
      if ((k < 32'(len)) && (j < msg_bytes - 1)) begin
        b = payload[8*k +: 8];
      end
    end
    return b;
  endfunction

endpackage

// ----- src/rfe_cell.sv -----
// One cell of the frame chain: loads its part of the frame, then passes it toward the head.
module rfe_cell import rfe_pkg::*; (
  input  logic          clk_i,
  input  rfe_cell_ctl_t ctl_i,
  input  rfe_cell_t     load_i,
  input  rfe_cell_t     next_i,
  output rfe_cell_t     cell_o
);

  rfe_cell_t cell_q, cell_d;

  always_comb begin
    cell_d = cell_q;
    if (ctl_i.load) begin
      cell_d = load_i;
    end else if (ctl_i.shift) begin
      cell_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ----- src/rfe_coder.sv -----
// Output stage: keys and line-codes message bytes, forms the checksum, registers each beat.
module rfe_coder import rfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        emit_i,
  input  rfe_cell_t   head_i,
  input  logic [7:0]  key_i,
  output logic        strobe_o,
  output rfe_result_t result_o
);

  logic [7:0]  sum_q, sum_d;
  logic        strobe_q;
  rfe_result_t result_q, result_d;
  logic [7:0]  plain;
  logic [7:0]  keyed;

  always_comb begin
    sum_d    = sum_q;
    result_d = result_q;
    plain    = head_i.lo;
    keyed    = 8'd0;
    if (emit_i) begin
      unique case (head_i.kind)
        KIND_MSG: begin
          plain = head_i.lo;
          sum_d = sum_q + head_i.lo;
        end
        KIND_SUM: begin
          // Two's complement of the running sum closes the message.
          plain = 8'd0 - sum_q;
          sum_d = 8'd0;
        end
        default: begin
          plain = head_i.lo;
        end
      endcase
      keyed = plain ^ key_i;
      if (head_i.kind == KIND_HDR) begin
        result_d.first_byte  = head_i.hi;
        result_d.second_byte = head_i.lo;
      end else begin
        result_d.first_byte  = {2'b00, code4to6(keyed[7:4])};
        result_d.second_byte = {2'b00, code4to6(keyed[3:0])};
      end
      result_d.last = (head_i.kind == KIND_SUM);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= 8'd0;
      strobe_q <= 1'b0;
    end else begin
      sum_q    <= sum_d;
      strobe_q <= emit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign strobe_o = strobe_q;
  assign result_o = result_q;

endmodule

// ----- src/rf_frame_builder_encoder.sv -----
// Top level of the RF frame builder and encoder: register file, cell chain and output stage.
//
// An accepted request loads the whole frame into a chain of 6 + MessageBytes cells at the
// accepting edge; the chain then moves one cell per cycle into the output stage, which puts
// one beat on result_o with out_strobe_o high for a single cycle. The first beat is shown once
// the loaded head cell has passed the output register and is taken at the edge that ends it. busy
// drops during the cycle that moves out the final cell, so a new request can be taken then and
// frames follow without a gap. The receiver cannot stall: every beat must be taken in the cycle
// it is shown. Configuration writes are always ready and must be made while no frame is in
// flight.
module rf_frame_builder_encoder import rfe_pkg::*; #(
  parameter int unsigned MessageBytes = MESSAGE_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  rfe_req_t             req_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i,
  output logic                 out_strobe_o,
  output rfe_result_t          result_o
);

  localparam int unsigned NumCells = HEADER_PAIRS + MessageBytes;
  localparam int unsigned CntW     = $clog2(NumCells + 1);

  logic [7:0]  key_q;
  logic [31:0] tx_id_q;
  logic [63:0] cnt_lo_q;
  logic [63:0] cnt_hi_q;

  logic [CntW-1:0] left_q, left_d;
  logic            accept;
  logic            emit;
  logic [2:0]      len;
  logic [7:0]      hdr_sum;
  rfe_cell_ctl_t   ctl;

  rfe_cell_t cells [NumCells];
  rfe_cell_t loads [NumCells];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= 8'd0;
      tx_id_q  <= 32'd0;
      cnt_lo_q <= 64'd0;
      cnt_hi_q <= 64'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_KEY:     key_q    <= cfg_data_i[7:0];
        CFG_TX_ID:   tx_id_q  <= cfg_data_i[31:0];
        CFG_CNT_LOW: cnt_lo_q <= cfg_data_i;
        CFG_CNT_HI:  cnt_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy   = (left_q > CntW'(1));
  assign accept = start && !busy;
  assign emit   = (left_q != '0);

  always_comb begin
    left_d = left_q;
    if (accept) begin
      left_d = CntW'(NumCells);
    end else if (emit) begin
      left_d = left_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else begin
      left_q <= left_d;
    end
  end

  assign ctl.load  = accept;
  assign ctl.shift = emit;

  assign len = (req_i.payload_len > 3'(MAX_PAYLOAD)) ? 3'(MAX_PAYLOAD) : req_i.payload_len;

  assign hdr_sum = req_i.header_random_a[7:0]  + req_i.header_random_a[15:8]
                 + req_i.header_random_a[23:16] + req_i.header_random_b[7:0]
                 + req_i.header_random_b[15:8]  + req_i.header_random_b[23:16]
                 + req_i.header_random_c[7:0]   + req_i.header_random_c[15:8];

  assign loads[0] = '{kind: KIND_HDR, hi: HDR_MARK_A, lo: req_i.header_random_a[7:0]};
  assign loads[1] = '{kind: KIND_HDR, hi: req_i.header_random_a[15:8],
                      lo: req_i.header_random_a[23:16]};
  assign loads[2] = '{kind: KIND_HDR, hi: HDR_MARK_B, lo: req_i.header_random_b[7:0]};
  assign loads[3] = '{kind: KIND_HDR, hi: req_i.header_random_b[15:8],
                      lo: req_i.header_random_b[23:16]};
  assign loads[4] = '{kind: KIND_HDR, hi: HDR_MARK_C, lo: req_i.header_random_c[7:0]};
  assign loads[5] = '{kind: KIND_HDR, hi: req_i.header_random_c[15:8], lo: hdr_sum};

  for (genvar j = 0; j < MessageBytes; j++) begin : g_msg_load
    if (j == MessageBytes - 1) begin : g_sum
      assign loads[HEADER_PAIRS+j] = '{kind: KIND_SUM, hi: 8'd0, lo: 8'd0};
    end else begin : g_data
      assign loads[HEADER_PAIRS+j] = '{kind: KIND_MSG, hi: 8'd0,
                                       lo: msg_byte(j, MessageBytes, cnt_lo_q, cnt_hi_q,
                                                    tx_id_q, req_i.id_salt, len,
                                                    req_i.payload)};
    end
  end

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rfe_cell_t next;
    if (i == NumCells - 1) begin : g_tail
      assign next = '{kind: KIND_HDR, hi: 8'd0, lo: 8'd0};
    end else begin : g_link
      assign next = cells[i+1];
    end
    rfe_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .load_i (loads[i]),
      .next_i (next),
      .cell_o (cells[i])
    );
  end

  rfe_coder u_coder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .emit_i   (emit),
    .head_i   (cells[0]),
    .key_i    (key_q),
    .strobe_o (out_strobe_o),
    .result_o (result_o)
  );

endmodule

// ----- src/rfe_checker.sv -----
// Port-level checks of the frame builder's command handshake and beat timing.
module rfe_checker import rfe_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        out_strobe_o,
  input rfe_result_t result_o
);

  // A taken request holds off further requests in the next cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted request");

  // A taken request's first beat shows after the cell and output registers.
  a_first_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 (out_strobe_o && !result_o.last))
    else $error("first beat missing after an accepted request");

  // While a frame is still being moved out, a beat follows every cycle.
  a_beat_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> out_strobe_o)
    else $error("gap in the beat stream while busy");

  // A last beat is always followed by idle or a fresh frame, never by more of the old one.
  a_last_then_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && result_o.last && !$past(start && !busy) |-> !busy)
    else $error("busy still high after the last beat");

endmodule

bind rf_frame_builder_encoder rfe_checker u_rfe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .out_strobe_o (out_strobe_o),
  .result_o     (result_o)
);

// ----- tb/rf_frame_builder_encoder_test.sv -----
// Self-checking testbench of the RF frame builder and encoder: predicted frames against result beats.
module rf_frame_builder_encoder_test;
  import rfe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned PHASE_ITEMS = 70;
  localparam int unsigned RANDOM_PHASES = 5;

  // 4-to-6 symbol for each nibble value, entry 0 in the low byte.
  localparam logic [15:0][7:0] NIBBLE_CODE = {
    8'h3f, 8'h3e, 8'h32, 8'h3a, 8'h39, 8'h26, 8'h25, 8'h23,
    8'h3c, 8'h2a, 8'h29, 8'h36, 8'h35, 8'h33, 8'h2e, 8'h2d
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  rfe_req_t             req_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [63:0]          cfg_data_i;
  logic                 out_strobe_o;
  rfe_result_t          result_o;

  // Shadow copy of the register file.
  logic [7:0]  key_q;
  logic [31:0] tx_id_q;
  logic [63:0] cnt_lo_q;
  logic [63:0] cnt_hi_q;

  rfe_result_t expected_pairs_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  rf_frame_builder_encoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_strobe_o (out_strobe_o),
    .result_o     (result_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats outstanding", $time, expected_pairs_q.size());
      $display("** rf_frame_builder_encoder: FAILED **");
      $finish;
    end
  end

  // Builds the whole frame for one request and queues its beats.
  task automatic predict_frame(input rfe_req_t rq);
    logic [7:0]  hdr [12];
    logic [7:0]  msg [MESSAGE_BYTES];
    logic [7:0]  sum;
    logic [7:0]  m;
    int unsigned len;
    rfe_result_t r;
    len = (rq.payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : rq.payload_len;
    hdr[0] = HDR_MARK_A;
    hdr[4] = HDR_MARK_B;
    hdr[8] = HDR_MARK_C;
    for (int i = 0; i < 3; i++) begin
      hdr[1 + i] = rq.header_random_a[8*i +: 8];
      hdr[5 + i] = rq.header_random_b[8*i +: 8];
    end
    hdr[9]  = rq.header_random_c[7:0];
    hdr[10] = rq.header_random_c[15:8];
    hdr[11] = hdr[1] + hdr[2] + hdr[3] + hdr[5] + hdr[6] + hdr[7] + hdr[9] + hdr[10];

    for (int j = 0; j < MESSAGE_BYTES; j++) msg[j] = PAD_BYTE;
    for (int i = 0; i < 8; i++) begin
      msg[i]     = cnt_lo_q[8*i +: 8];
      msg[8 + i] = cnt_hi_q[8*i +: 8];
    end
    for (int i = 0; i < 4; i++) begin
      msg[16 + 2*i] = tx_id_q[8*i +: 8];
      msg[17 + 2*i] = rq.id_salt[8*i +: 8];
    end
    msg[24] = 8'(len);
    // Payload bytes that would land on the checksum are dropped.
    for (int i = 0; i < len; i++) begin
      if (25 + i < MESSAGE_BYTES - 1) msg[25 + i] = rq.payload[8*i +: 8];
    end
    sum = 8'd0;
    for (int j = 0; j < MESSAGE_BYTES - 1; j++) sum = sum + msg[j];
    msg[MESSAGE_BYTES - 1] = 8'd0 - sum;

    for (int i = 0; i < HEADER_PAIRS; i++) begin
      r.first_byte  = hdr[2*i];
      r.second_byte = hdr[2*i + 1];
      r.last        = 1'b0;
      expected_pairs_q.push_back(r);
    end
    for (int j = 0; j < MESSAGE_BYTES; j++) begin
      m = msg[j] ^ key_q;
      r.first_byte  = NIBBLE_CODE[m[7:4]];
      r.second_byte = NIBBLE_CODE[m[3:0]];
      r.last        = (j == MESSAGE_BYTES - 1);
      expected_pairs_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  // The receiver never stalls, so every strobed beat is taken at the edge that ends it.
  always @(posedge clk_i) begin
    rfe_result_t want;
    if (rst_ni && out_strobe_o) begin
      if (expected_pairs_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected beat expected none, got %h %h last %b", $time,
                 result_o.first_byte, result_o.second_byte, result_o.last);
      end else begin
        want = expected_pairs_q.pop_front();
        check_field("first_byte", want.first_byte, result_o.first_byte);
        check_field("second_byte", want.second_byte, result_o.second_byte);
        check_field("last", 8'(want.last), 8'(result_o.last));
      end
    end
  end

  // Leaves start high after the accepting edge so that a zero gap gives back-to-back requests.
  task automatic send_request(input rfe_req_t rq);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      do @(posedge clk_i); while (busy);
      repeat (gap - 1) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
    predict_frame(rq);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    repeat ($urandom_range(1, 3)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_KEY:     key_q    = data[7:0];
      CFG_TX_ID:   tx_id_q  = data[31:0];
      CFG_CNT_LOW: cnt_lo_q = data;
      CFG_CNT_HI:  cnt_hi_q = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [63:0] k, input logic [63:0] id,
                           input logic [63:0] lo, input logic [63:0] hi);
    write_reg(CFG_KEY, k);
    write_reg(CFG_TX_ID, id);
    write_reg(CFG_CNT_LOW, lo);
    write_reg(CFG_CNT_HI, hi);
  endtask

  // Stops requesting and waits until the last frame has gone out.
  task automatic finish_frames();
    start <= 1'b0;
    while (expected_pairs_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic rfe_req_t rand_request();
    rfe_req_t rq;
    rq.payload         = {8'($urandom), 32'($urandom)};
    rq.payload_len     = 3'($urandom_range(0, 7));
    rq.id_salt         = $urandom;
    rq.header_random_a = 24'($urandom);
    rq.header_random_b = 24'($urandom);
    rq.header_random_c = 16'($urandom);
    return rq;
  endfunction

  task automatic test_reset_registers();
    rfe_req_t rq;
    send_request('0);
    send_request('1);
    rq = rand_request();
    rq.payload_len = 3'd5;
    send_request(rq);
    finish_frames();
  endtask

  task automatic test_register_extremes();
    rfe_req_t rq;
    configure('1, '1, '1, '1);
    send_request('0);
    send_request('1);
    rq = rand_request();
    rq.payload_len = 3'd6;
    send_request(rq);
    finish_frames();
    // Every length from 0 to MAX_PAYLOAD with all payload bits set shows that bytes past the length are ignored.
    configure(64'hA5, 64'h1234_5678, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    for (int n = 0; n <= MAX_PAYLOAD; n++) begin
      rq = rand_request();
      rq.payload = '1;
      rq.payload_len = 3'(n);
      send_request(rq);
    end
    finish_frames();
  endtask

  task automatic test_unknown_index();
    for (int idx = int'(CFG_CNT_HI) + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(CFG_IDX_W'(idx), '1);
    end
    send_request(rand_request());
    send_request(rand_request());
    finish_frames();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure(rand_word(), rand_word(), rand_word(), rand_word());
      repeat (PHASE_ITEMS) send_request(rand_request());
      finish_frames();
    end
  endtask

  initial begin
    key_q        = '0;
    tx_id_q      = '0;
    cnt_lo_q     = '0;
    cnt_hi_q     = '0;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    req_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_registers();
    test_register_extremes();
    test_unknown_index();
    test_random_phases();

    if (mismatch_cnt == 0) begin
      $display("** rf_frame_builder_encoder: PASSED **");
    end else begin
      $display("** rf_frame_builder_encoder: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/rfe_pkg.sv
src/rfe_cell.sv
src/rfe_coder.sv
src/rf_frame_builder_encoder.sv
src/rfe_checker.sv
tb/rf_frame_builder_encoder_test.sv
